[src/bpa_pkg.sv]
// Shared types, sizes and helper functions of the buddy page allocator.
package bpa_pkg;

  localparam int unsigned MAX_PAGES = 1024;
  localparam int unsigned NODES     = 2 * MAX_PAGES - 1;
  localparam int unsigned NODE_W    = $clog2(NODES);
  localparam int unsigned PG_W      = 11;
  localparam int unsigned OFF_W     = 10;
  localparam int unsigned WANT_W    = PG_W + 1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [PG_W-1:0]   request_pages;
    logic [OFF_W-1:0]  block_start;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [OFF_W-1:0]  granted_start;
    logic [PG_W-1:0]   block_pages;
    logic [PG_W-1:0]   pages_left;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [PG_W-1:0]   wdata;
    logic [NODE_W-1:0] raddr;
  } mem_req_t;

  // Highest set bit of v kept alone; zero stays zero.
  function automatic logic [PG_W-1:0] pow2_floor(input logic [PG_W-1:0] v);
    logic [PG_W-1:0] r;
    r = '0;
    for (int i = 0; i < PG_W; i++) begin
      if (v[i]) begin
        r    = '0;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  // Smallest power of two not below v; zero and one give one.
  function automatic logic [WANT_W-1:0] pow2_ceil(input logic [PG_W-1:0] v);
    logic [PG_W-1:0]   m;
    logic [WANT_W-1:0] r;
    m = v - PG_W'(1);
    r = WANT_W'(1);
    if (v > PG_W'(1)) begin
      for (int i = 0; i < PG_W; i++) begin
        if (m[i]) begin
          r      = '0;
          r[i+1] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Buddy of a non-root node.
  function automatic logic [NODE_W-1:0] sibling(input logic [NODE_W-1:0] n);
    return n[0] ? n + NODE_W'(1) : n - NODE_W'(1);
  endfunction

endpackage

[src/bpa_tree_mem.sv]
// Tree node memory: one write port, one read port with registered data.
module bpa_tree_mem (
  input  logic                         clk,
  input  bpa_pkg::mem_req_t            req,
  output logic [bpa_pkg::PG_W-1:0]     rdata
);

  logic [bpa_pkg::PG_W-1:0] tree [0:bpa_pkg::NODES-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      tree[req.waddr] <= req.wdata;
    end
    rdata <= tree[req.raddr];
  end

endmodule

[src/bpa_walk.sv]
// Tree walk engine: rebuild sweep, alloc descent, free climb and ancestor update.
module bpa_walk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_load,
  input  logic [bpa_pkg::PG_W-1:0]     cfg_pool,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bpa_pkg::in_word_t            in_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output bpa_pkg::out_word_t           res,
  output bpa_pkg::mem_req_t            mem,
  input  logic [bpa_pkg::PG_W-1:0]     rdata
);

  localparam int unsigned NW = bpa_pkg::NODE_W;
  localparam int unsigned PW = bpa_pkg::PG_W;
  localparam int unsigned OW = bpa_pkg::OFF_W;
  localparam int unsigned WW = bpa_pkg::WANT_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_A_ROOT, ST_A_DOWN, ST_F_UP, ST_ASC, ST_DONE
  } state_t;

  state_t          state;
  logic [NW-1:0]   clr_node;
  logic [PW-1:0]   clr_val;
  logic [PW-1:0]   pool;
  logic [PW-1:0]   free_count;
  logic [NW-1:0]   node;
  logic [PW-1:0]   size;
  logic [WW-1:0]   want;
  logic [OW-1:0]   off;
  logic [PW-1:0]   cur_val;
  logic            merge;
  logic            res_ok;
  logic [OW-1:0]   res_start;
  logic [PW-1:0]   res_pages;
  logic [PW-1:0]   res_free;

  logic [NW:0]     clr_n1;
  logic [NW:0]     clr_n2;
  logic            clr_lvl;
  logic [NW-1:0]   left_c;
  logic [NW-1:0]   child_c;
  logic [NW-1:0]   parent_c;
  logic [NW-1:0]   leaf_c;
  logic            go_left;
  logic            fits;
  logic            reach;
  logic [PW-1:0]   half;
  logic [PW-1:0]   sizep;
  logic [PW:0]     sum;
  logic [PW-1:0]   maxv;
  logic [PW-1:0]   merged;
  logic [OW-1:0]   off_c;
  logic [WW-1:0]   want_c;
  logic            start_ok;

  assign clr_n1   = {1'b0, clr_node} + (NW+1)'(1);
  assign clr_n2   = clr_n1 + (NW+1)'(1);
  assign clr_lvl  = ((clr_n1 & clr_n2) == '0);

  assign left_c   = {node[NW-2:0], 1'b1};
  assign go_left  = ({1'b0, rdata} >= want);
  assign child_c  = go_left ? left_c : left_c + NW'(1);
  assign half     = size >> 1;
  assign reach    = ({1'b0, half} == want);
  assign off_c    = go_left ? off : off + half[OW-1:0];
  assign parent_c = (node - NW'(1)) >> 1;
  assign fits     = ({1'b0, rdata} >= want);

  assign sizep    = size << 1;
  assign sum      = {1'b0, cur_val} + {1'b0, rdata};
  assign maxv     = (cur_val > rdata) ? cur_val : rdata;
  assign merged   = (merge && sum == {1'b0, sizep}) ? sizep : maxv;

  assign leaf_c   = NW'(in_data.block_start) + NW'(pool) - NW'(1);
  assign start_ok = ({1'b0, in_data.block_start} < pool);
  assign want_c   = bpa_pkg::pow2_ceil(in_data.request_pages);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = '{ok: res_ok, granted_start: res_start,
                       block_pages: res_pages, pages_left: res_free};

  always_comb begin
    mem = '{we: 1'b0, waddr: node, wdata: '0, raddr: node};
    unique case (state)
      ST_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = clr_node;
        mem.wdata = clr_val;
      end
      ST_IDLE: begin
        mem.raddr = (in_data.action == bpa_pkg::ACT_ALLOC) ? '0 : leaf_c;
      end
      ST_A_ROOT: begin
        if (fits && {1'b0, size} == want) begin
          mem.we    = 1'b1;
          mem.waddr = '0;
        end
        mem.raddr = NW'(1);
      end
      ST_A_DOWN: begin
        if (reach) begin
          mem.we    = 1'b1;
          mem.waddr = child_c;
          mem.raddr = bpa_pkg::sibling(child_c);
        end else begin
          mem.raddr = {child_c[NW-2:0], 1'b1};
        end
      end
      ST_F_UP: begin
        if (rdata == '0) begin
          mem.we    = 1'b1;
          mem.waddr = node;
          mem.wdata = size;
          mem.raddr = (node == '0) ? '0 : bpa_pkg::sibling(node);
        end else begin
          mem.raddr = parent_c;
        end
      end
      ST_ASC: begin
        mem.we    = 1'b1;
        mem.waddr = parent_c;
        mem.wdata = merged;
        mem.raddr = (parent_c == '0) ? '0 : bpa_pkg::sibling(parent_c);
      end
      ST_DONE: begin
        mem.we = 1'b0;
      end
      default: begin
        mem.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_node   <= '0;
      clr_val    <= PW'(bpa_pkg::MAX_PAGES);
      pool       <= PW'(bpa_pkg::MAX_PAGES);
      free_count <= PW'(bpa_pkg::MAX_PAGES);
    end else if (cfg_load) begin
      state      <= ST_CLEAR;
      clr_node   <= '0;
      clr_val    <= cfg_pool;
      pool       <= cfg_pool;
      free_count <= cfg_pool;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_node <= clr_n1[NW-1:0];
          if (clr_lvl) begin
            clr_val <= clr_val >> 1;
          end
          if (clr_node == NW'(bpa_pkg::NODES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          res_ok    <= 1'b0;
          res_start <= '0;
          res_pages <= '0;
          res_free  <= free_count;
          if (in_valid) begin
            if (in_data.action == bpa_pkg::ACT_ALLOC) begin
              want  <= want_c;
              node  <= '0;
              size  <= pool;
              off   <= '0;
              state <= ST_A_ROOT;
            end else if (start_ok) begin
              node  <= leaf_c;
              size  <= PW'(1);
              state <= ST_F_UP;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_A_ROOT: begin
          if (!fits) begin
            state <= ST_DONE;
          end else if ({1'b0, size} == want) begin
            // whole pool granted, no ancestors to fix
            res_ok     <= 1'b1;
            res_pages  <= want[PW-1:0];
            free_count <= free_count - want[PW-1:0];
            res_free   <= free_count - want[PW-1:0];
            state      <= ST_DONE;
          end else begin
            state <= ST_A_DOWN;
          end
        end
        ST_A_DOWN: begin
          node <= child_c;
          size <= half;
          off  <= off_c;
          if (reach) begin
            cur_val    <= '0;
            merge      <= 1'b0;
            res_ok     <= 1'b1;
            res_start  <= off_c;
            res_pages  <= want[PW-1:0];
            free_count <= free_count - want[PW-1:0];
            res_free   <= free_count - want[PW-1:0];
            state      <= ST_ASC;
          end
        end
        ST_F_UP: begin
          if (rdata == '0) begin
            cur_val    <= size;
            merge      <= 1'b1;
            res_ok     <= 1'b1;
            res_pages  <= size;
            free_count <= free_count + size;
            res_free   <= free_count + size;
            state      <= (node == '0) ? ST_DONE : ST_ASC;
          end else if (node == '0) begin
            state <= ST_DONE;
          end else begin
            node <= parent_c;
            size <= sizep;
          end
        end
        ST_ASC: begin
          node    <= parent_c;
          size    <= sizep;
          cur_val <= merged;
          if (parent_c == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_free_le_pool: assert property (@(posedge clk) disable iff (rst)
    free_count <= pool)
    else $error("free page count above pool size");

  a_asc_not_root: assert property (@(posedge clk) disable iff (rst)
    state == ST_ASC |-> node != '0)
    else $error("ancestor update started at the root");

  a_ok_pow2: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_ok) |-> $onehot(res_pages))
    else $error("granted or freed size not a power of two");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mem.we)
    else $error("tree written while idle");

  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_load |=> (state == ST_CLEAR && free_count == $past(cfg_pool)))
    else $error("pool write did not start rebuild");
`endif

endmodule

[src/buddy_page_allocator_unit.sv]
// Each word takes one memory access per tree level going down and one per level going up,
//   from the accepting edge to out_valid. The walk handles one word at a time, set by the single
//   read port of the node memory; a new word is taken while an earlier result waits in the
//   output register. Reset and every pool write start a rebuild sweep of every node of the
//   node memory, one node per cycle; no word is accepted during the sweep.
module buddy_page_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bpa_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bpa_pkg::out_word_t           out_data,
  input  logic                         cfg_we,
  input  logic [bpa_pkg::PG_W-1:0]     cfg_wdata
);

  localparam int unsigned PW = bpa_pkg::PG_W;

  bpa_pkg::mem_req_t   mem;
  logic [PW-1:0]       rdata;
  logic                res_valid;
  logic                res_ready;
  bpa_pkg::out_word_t  res;
  logic [PW-1:0]       cfg_pool;

  // pool size: zero counts as one, saturate, then floor to a power of two
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_pool = PW'(1);
    end else if (cfg_wdata > PW'(bpa_pkg::MAX_PAGES)) begin
      cfg_pool = PW'(bpa_pkg::MAX_PAGES);
    end else begin
      cfg_pool = bpa_pkg::pow2_floor(cfg_wdata);
    end
  end

  bpa_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg_load  (cfg_we),
    .cfg_pool  (cfg_pool),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem       (mem),
    .rdata     (rdata)
  );

  bpa_tree_mem u_mem (
    .clk   (clk),
    .req   (mem),
    .rdata (rdata)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

endmodule
